FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define OTWO_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define OTWO_ASSERT_RST(name, prop) \
    name: assert property (@(posedge i_clk) prop) else $error("assertion failed");
`else
`define OTWO_ASSERT(name, prop)
`define OTWO_ASSERT_RST(name, prop)
`endif
`endif

FILE: rtl/otwo_pkg.sv
// ---------------------------------------------------------------------------
// otwo_pkg
// Types, constants and micro-op table for the three-wheel odometry block.
// ---------------------------------------------------------------------------
`default_nettype none
package otwo_pkg;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG  = 8'd1;

    localparam logic [31:0] DF_RESET = 32'd14055248;
    localparam logic [31:0] AF_RESET = 32'd5490330;

    localparam logic signed [32:0] K_TH = 33'sd1780063;
    localparam logic signed [32:0] K_XA = 33'sd195734746;
    localparam logic signed [32:0] K_XB = 33'sd391462781;
    localparam logic signed [32:0] K_Y  = 33'sd339022237;

    localparam logic signed [33:0] Q_PI   = 34'sd52707179;
    localparam logic signed [33:0] Q_2PI  = 34'sd105414357;
    localparam logic signed [33:0] Q_HPI  = 34'sd26353589;
    localparam logic signed [33:0] C_GAIN = 34'sd652032874;

    localparam logic [4:0] CORDIC_LAST = 5'd23;
    localparam logic [4:0] K_PRE_ROT   = 5'd21;
    localparam logic [4:0] K_LAST      = 5'd29;

    typedef enum logic [3:0] {
        A_C1, A_C2, A_C3, A_T1, A_T2, A_T3, A_W1, A_W2, A_W3,
        A_DX, A_DY, A_BVX, A_BVY
    } t_asel;

    typedef enum logic [3:0] {
        B_DF, B_AF, B_NKTH, B_KXA, B_NKXB, B_KY, B_NKY, B_CS, B_SN, B_NSN
    } t_bsel;

    typedef enum logic [4:0] {
        D_NONE, D_T1, D_T2, D_T3, D_W1, D_W2, D_W3, D_HEAD, D_DX, D_DY,
        D_BVX, D_BVY, D_VTH, D_PX, D_PY, D_VX, D_VY
    } t_dest;

    typedef enum logic [1:0] {SH_8, SH_24, SH_30, SH_32} t_shift;

    typedef struct packed {
        t_asel  asel;
        t_bsel  bsel;
        logic   first;
        t_dest  dest;
        t_shift sh;
    } t_uop;

    function automatic t_uop mk(t_asel a, t_bsel b, logic f, t_dest d, t_shift s);
        t_uop u;
        u.asel  = a;
        u.bsel  = b;
        u.first = f;
        u.dest  = d;
        u.sh    = s;
        return u;
    endfunction

    // one product per step, result written back on the last term of a sum
    function automatic t_uop uop_at(logic [4:0] k);
        t_uop u;
        case (k)
            5'd0:  u = mk(A_C1,  B_DF,   1'b1, D_T1,   SH_8);
            5'd1:  u = mk(A_C2,  B_DF,   1'b1, D_T2,   SH_8);
            5'd2:  u = mk(A_C3,  B_DF,   1'b1, D_T3,   SH_8);
            5'd3:  u = mk(A_C1,  B_AF,   1'b1, D_W1,   SH_8);
            5'd4:  u = mk(A_C2,  B_AF,   1'b1, D_W2,   SH_8);
            5'd5:  u = mk(A_C3,  B_AF,   1'b1, D_W3,   SH_8);
            5'd6:  u = mk(A_T1,  B_NKTH, 1'b1, D_NONE, SH_24);
            5'd7:  u = mk(A_T2,  B_NKTH, 1'b0, D_NONE, SH_24);
            5'd8:  u = mk(A_T3,  B_NKTH, 1'b0, D_HEAD, SH_24);
            5'd9:  u = mk(A_T1,  B_KXA,  1'b1, D_NONE, SH_32);
            5'd10: u = mk(A_T2,  B_KXA,  1'b0, D_NONE, SH_32);
            5'd11: u = mk(A_T3,  B_NKXB, 1'b0, D_DX,   SH_32);
            5'd12: u = mk(A_T1,  B_NKY,  1'b1, D_NONE, SH_32);
            5'd13: u = mk(A_T2,  B_KY,   1'b0, D_DY,   SH_32);
            5'd14: u = mk(A_W1,  B_KXA,  1'b1, D_NONE, SH_24);
            5'd15: u = mk(A_W2,  B_KXA,  1'b0, D_NONE, SH_24);
            5'd16: u = mk(A_W3,  B_NKXB, 1'b0, D_BVX,  SH_24);
            5'd17: u = mk(A_W1,  B_NKY,  1'b1, D_NONE, SH_24);
            5'd18: u = mk(A_W2,  B_KY,   1'b0, D_BVY,  SH_24);
            5'd19: u = mk(A_W1,  B_NKTH, 1'b1, D_NONE, SH_24);
            5'd20: u = mk(A_W2,  B_NKTH, 1'b0, D_NONE, SH_24);
            5'd21: u = mk(A_W3,  B_NKTH, 1'b0, D_VTH,  SH_24);
            5'd22: u = mk(A_DX,  B_CS,   1'b1, D_NONE, SH_30);
            5'd23: u = mk(A_DY,  B_NSN,  1'b0, D_PX,   SH_30);
            5'd24: u = mk(A_DX,  B_SN,   1'b1, D_NONE, SH_30);
            5'd25: u = mk(A_DY,  B_CS,   1'b0, D_PY,   SH_30);
            5'd26: u = mk(A_BVX, B_CS,   1'b1, D_NONE, SH_30);
            5'd27: u = mk(A_BVY, B_NSN,  1'b0, D_VX,   SH_30);
            5'd28: u = mk(A_BVX, B_SN,   1'b1, D_NONE, SH_30);
            5'd29: u = mk(A_BVY, B_CS,   1'b0, D_VY,   SH_30);
            default: u = mk(A_C1, B_DF,  1'b1, D_NONE, SH_8);
        endcase
        return u;
    endfunction

    function automatic logic signed [33:0] atan_at(logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd13176795;
            5'd1:  v = 34'sd7778716;
            5'd2:  v = 34'sd4110060;
            5'd3:  v = 34'sd2086331;
            5'd4:  v = 34'sd1047214;
            5'd5:  v = 34'sd524117;
            5'd6:  v = 34'sd262123;
            5'd7:  v = 34'sd131069;
            5'd8:  v = 34'sd65536;
            5'd9:  v = 34'sd32768;
            5'd10: v = 34'sd16384;
            5'd11: v = 34'sd8192;
            5'd12: v = 34'sd4096;
            5'd13: v = 34'sd2048;
            5'd14: v = 34'sd1024;
            5'd15: v = 34'sd512;
            5'd16: v = 34'sd256;
            5'd17: v = 34'sd128;
            5'd18: v = 34'sd64;
            5'd19: v = 34'sd32;
            5'd20: v = 34'sd16;
            5'd21: v = 34'sd8;
            5'd22: v = 34'sd4;
            5'd23: v = 34'sd2;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [68:0] v);
        logic signed [31:0] r;
        if (v > 69'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -69'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/omni_three_wheel_odometry.sv
// ---------------------------------------------------------------------------
// omni_three_wheel_odometry
// Dead-reckoning pose and velocity for a three-wheel omni base, built on one
// shared 33x33 multiply-accumulate unit and an iterative CORDIC.
// ---------------------------------------------------------------------------
// Sequence: a preset word goes straight to the output register; an update word
//   runs 30 multiply/accumulate passes of the shared multiplier (multiply,
//   then accumulate), 16 write-backs, the heading reduction, 24 CORDIC steps
//   and the fold, sign, wrap and output steps; output waits on m_axis_tready.
// Throughput: one word at a time; input not ready until the result is queued.
// Reset: synchronous active low; pose zero, factors to their defaults.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module omni_three_wheel_odometry #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     s_axis_tvalid,
    output logic                                    s_axis_tready,
    // count_1, count_2, count_3, pose_x_in, pose_y_in, heading_in, zero pad
    input  wire [((3*COUNT_WIDTH+96+7)/8)*8-1:0]    s_axis_tdata,
    // req_type
    input  wire                                     s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire                                     m_axis_tready,
    // pos_x, pos_y, heading_out, vel_x, vel_y, vel_heading,
    // wheel_speed_1, wheel_speed_2, wheel_speed_3
    output logic [287:0]                            m_axis_tdata,
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire [otwo_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  wire [31:0]                              i_cfg_data
);

    localparam int CW = COUNT_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_FIN, S_RED, S_FOLD, S_CORD, S_CSN, S_WRAP, S_DONE
    } t_state;

    t_state r_state;

    logic [31:0] r_df, r_af;
    logic signed [31:0] r_px, r_py, r_head;
    logic signed [CW-1:0] r_c1, r_c2, r_c3;
    logic signed [31:0] r_t1, r_t2, r_t3, r_w1, r_w2, r_w3;
    logic signed [31:0] r_dx, r_dy, r_bvx, r_bvy, r_vth, r_vx, r_vy;
    logic signed [32:0] r_cs, r_sn;
    logic signed [65:0] r_prod;
    logic signed [67:0] r_acc;
    logic [4:0] r_k, r_i;
    logic signed [33:0] r_ang, r_cx, r_cy;
    logic r_neg, r_ovalid;
    logic [287:0] r_odata;

    otwo_pkg::t_uop uop;
    logic signed [32:0] mul_a, mul_b;
    logic signed [67:0] n_acc, rnd, shd;
    logic signed [68:0] base, fsum;
    logic signed [31:0] fin;
    logic signed [33:0] fold0, n_fang, xs, ys;
    logic n_fneg;
    logic in_acc;
    logic [31:0] head_in;

    assign uop = otwo_pkg::uop_at(r_k);
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign head_in = s_axis_tdata[3*CW+95:3*CW+64];

    always_comb begin
        case (uop.asel)
            otwo_pkg::A_C1:  mul_a = 33'(r_c1);
            otwo_pkg::A_C2:  mul_a = 33'(r_c2);
            otwo_pkg::A_C3:  mul_a = 33'(r_c3);
            otwo_pkg::A_T1:  mul_a = 33'(r_t1);
            otwo_pkg::A_T2:  mul_a = 33'(r_t2);
            otwo_pkg::A_T3:  mul_a = 33'(r_t3);
            otwo_pkg::A_W1:  mul_a = 33'(r_w1);
            otwo_pkg::A_W2:  mul_a = 33'(r_w2);
            otwo_pkg::A_W3:  mul_a = 33'(r_w3);
            otwo_pkg::A_DX:  mul_a = 33'(r_dx);
            otwo_pkg::A_DY:  mul_a = 33'(r_dy);
            otwo_pkg::A_BVX: mul_a = 33'(r_bvx);
            otwo_pkg::A_BVY: mul_a = 33'(r_bvy);
            default:         mul_a = 33'sd0;
        endcase
        case (uop.bsel)
            otwo_pkg::B_DF:   mul_b = $signed({1'b0, r_df});
            otwo_pkg::B_AF:   mul_b = $signed({1'b0, r_af});
            otwo_pkg::B_NKTH: mul_b = -otwo_pkg::K_TH;
            otwo_pkg::B_KXA:  mul_b = otwo_pkg::K_XA;
            otwo_pkg::B_NKXB: mul_b = -otwo_pkg::K_XB;
            otwo_pkg::B_KY:   mul_b = otwo_pkg::K_Y;
            otwo_pkg::B_NKY:  mul_b = -otwo_pkg::K_Y;
            otwo_pkg::B_CS:   mul_b = r_cs;
            otwo_pkg::B_SN:   mul_b = r_sn;
            otwo_pkg::B_NSN:  mul_b = -r_sn;
            default:          mul_b = 33'sd0;
        endcase
    end

    always_comb begin
        n_acc = (uop.first ? 68'sd0 : r_acc) + 68'(r_prod);
        case (uop.sh)
            otwo_pkg::SH_8:  begin rnd = r_acc + 68'sd128;        shd = rnd >>> 8;  end
            otwo_pkg::SH_24: begin rnd = r_acc + 68'sd8388608;    shd = rnd >>> 24; end
            otwo_pkg::SH_30: begin rnd = r_acc + 68'sd536870912;  shd = rnd >>> 30; end
            default:         begin rnd = r_acc + 68'sd2147483648; shd = rnd >>> 32; end
        endcase
        case (uop.dest)
            otwo_pkg::D_HEAD: base = 69'(r_head);
            otwo_pkg::D_PX:   base = 69'(r_px);
            otwo_pkg::D_PY:   base = 69'(r_py);
            default:          base = 69'sd0;
        endcase
        fsum = 69'(shd) + base;
        fin = otwo_pkg::sat32(fsum);
    end

    // reduced angle into (-pi, pi], then folded into [-pi/2, pi/2]
    always_comb begin
        fold0 = (r_ang > otwo_pkg::Q_PI) ? r_ang - otwo_pkg::Q_2PI : r_ang;
        n_fneg = 1'b0;
        n_fang = fold0;
        if (fold0 > otwo_pkg::Q_HPI) begin
            n_fang = fold0 - otwo_pkg::Q_PI;
            n_fneg = 1'b1;
        end else if (fold0 < -otwo_pkg::Q_HPI) begin
            n_fang = fold0 + otwo_pkg::Q_PI;
            n_fneg = 1'b1;
        end
        xs = r_cx >>> r_i;
        ys = r_cy >>> r_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_df     <= otwo_pkg::DF_RESET;
            r_af     <= otwo_pkg::AF_RESET;
            r_px     <= 32'sd0;
            r_py     <= 32'sd0;
            r_head   <= 32'sd0;
            r_k      <= 5'd0;
            r_i      <= 5'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    otwo_pkg::CFG_DIST: r_df <= i_cfg_data;
                    otwo_pkg::CFG_ANG:  r_af <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_c1 <= s_axis_tdata[CW-1:0];
                        r_c2 <= s_axis_tdata[2*CW-1:CW];
                        r_c3 <= s_axis_tdata[3*CW-1:2*CW];
                        r_k  <= 5'd0;
                        if (s_axis_tuser) begin
                            r_px   <= s_axis_tdata[3*CW+31:3*CW];
                            r_py   <= s_axis_tdata[3*CW+63:3*CW+32];
                            r_head <= head_in;
                            r_vx   <= 32'sd0;
                            r_vy   <= 32'sd0;
                            r_vth  <= 32'sd0;
                            r_w1   <= 32'sd0;
                            r_w2   <= 32'sd0;
                            r_w3   <= 32'sd0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= n_acc;
                    if (uop.dest != otwo_pkg::D_NONE) begin
                        r_state <= S_FIN;
                    end else begin
                        r_k     <= r_k + 5'd1;
                        r_state <= S_MUL;
                    end
                end
                S_FIN: begin
                    case (uop.dest)
                        otwo_pkg::D_T1:   r_t1   <= fin;
                        otwo_pkg::D_T2:   r_t2   <= fin;
                        otwo_pkg::D_T3:   r_t3   <= fin;
                        otwo_pkg::D_W1:   r_w1   <= fin;
                        otwo_pkg::D_W2:   r_w2   <= fin;
                        otwo_pkg::D_W3:   r_w3   <= fin;
                        otwo_pkg::D_HEAD: r_head <= fin;
                        otwo_pkg::D_DX:   r_dx   <= fin;
                        otwo_pkg::D_DY:   r_dy   <= fin;
                        otwo_pkg::D_BVX:  r_bvx  <= fin;
                        otwo_pkg::D_BVY:  r_bvy  <= fin;
                        otwo_pkg::D_VTH:  r_vth  <= fin;
                        otwo_pkg::D_PX:   r_px   <= fin;
                        otwo_pkg::D_PY:   r_py   <= fin;
                        otwo_pkg::D_VX:   r_vx   <= fin;
                        otwo_pkg::D_VY:   r_vy   <= fin;
                        default: ;
                    endcase
                    if (r_k == otwo_pkg::K_PRE_ROT) begin
                        r_ang   <= 34'(r_head);
                        r_state <= S_RED;
                    end else if (r_k == otwo_pkg::K_LAST) begin
                        r_state <= S_WRAP;
                    end else begin
                        r_state <= S_MUL;
                    end
                    r_k <= r_k + 5'd1;
                end
                S_RED: begin
                    if (r_ang < 34'sd0) begin
                        r_ang <= r_ang + otwo_pkg::Q_2PI;
                    end else if (r_ang >= otwo_pkg::Q_2PI) begin
                        r_ang <= r_ang - otwo_pkg::Q_2PI;
                    end else begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_ang   <= n_fang;
                    r_neg   <= n_fneg;
                    r_cx    <= otwo_pkg::C_GAIN;
                    r_cy    <= 34'sd0;
                    r_i     <= 5'd0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (!r_ang[33]) begin
                        r_cx  <= r_cx - ys;
                        r_cy  <= r_cy + xs;
                        r_ang <= r_ang - otwo_pkg::atan_at(r_i);
                    end else begin
                        r_cx  <= r_cx + ys;
                        r_cy  <= r_cy - xs;
                        r_ang <= r_ang + otwo_pkg::atan_at(r_i);
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == otwo_pkg::CORDIC_LAST) begin
                        r_state <= S_CSN;
                    end
                end
                S_CSN: begin
                    r_cs    <= r_neg ? -r_cx[32:0] : r_cx[32:0];
                    r_sn    <= r_neg ? -r_cy[32:0] : r_cy[32:0];
                    r_state <= S_MUL;
                end
                S_WRAP: begin
                    if (34'(r_head) > otwo_pkg::Q_PI) begin
                        r_head <= r_head - otwo_pkg::Q_2PI[31:0];
                    end else if (34'(r_head) < -otwo_pkg::Q_PI) begin
                        r_head <= r_head + otwo_pkg::Q_2PI[31:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= {r_w3, r_w2, r_w1, r_vth, r_vy, r_vx,
                                     r_head, r_py, r_px};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `OTWO_ASSERT(a_busy_after_accept, in_acc |=> !s_axis_tready)
    `OTWO_ASSERT(a_step_range, (r_k <= otwo_pkg::K_LAST + 5'd1))
    `OTWO_ASSERT(a_preset_heading, (in_acc && s_axis_tuser) |=> (r_head == $past(head_in)))
    `OTWO_ASSERT_RST(a_reset_idle, !i_rst_n |=> (s_axis_tready && !m_axis_tvalid))

endmodule
`default_nettype wire
